// ===== rtl/core/bitmap_block_allocator_top_assert.svh =====
// Assertion macros used by the checker of the block allocator.
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bba assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bba assertion failed");

`endif

// ===== rtl/core/bba_pkg.sv =====
// Shared constants, types and helper functions of the block allocator.
package bba_pkg;

  // Map geometry.
  localparam int MAP_WORDS   = 128;
  localparam int MAP_BITS    = 4096;
  localparam int WORD_W      = 32;
  localparam int WADDR_W     = 7;
  localparam int BLK_W       = 12;
  localparam int DISK_BLOCKS = 4096;
  localparam int DISK_LIMIT  = (DISK_BLOCKS < MAP_BITS) ? DISK_BLOCKS : MAP_BITS;

  // One past the last block that may be granted, one bit wider than a block number.
  localparam logic [BLK_W:0]     LIMIT_BLK = (BLK_W + 1)'(DISK_LIMIT);
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(MAP_WORDS - 1);

  // Action codes.
  localparam logic [2:0] ACT_ALLOC  = 3'd0;
  localparam logic [2:0] ACT_FREE   = 3'd1;
  localparam logic [2:0] ACT_FORMAT = 3'd2;
  localparam logic [2:0] ACT_LOAD   = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;
  localparam logic [2:0] ACT_CLEAN  = 3'd5;

  // Configuration register indexes and reset values.
  localparam int         PADDR_W     = 4;
  localparam logic [1:0] REG_FIRST   = 2'd0;
  localparam logic [1:0] REG_RSTART  = 2'd1;
  localparam logic [1:0] REG_RBLOCKS = 2'd2;

  localparam logic [BLK_W-1:0] FIRST_RESET   = 12'd16;
  localparam logic [BLK_W-1:0] RSTART_RESET  = 12'd2;
  localparam logic [BLK_W-1:0] RBLOCKS_RESET = 12'd1;
  localparam logic [BLK_W-1:0] HINT_RESET    = 12'd16;

  // Read and write access to the map store, both in the same cycle.
  typedef struct packed {
    logic               rd_en;
    logic [WADDR_W-1:0] rd_addr;
    logic               wr_en;
    logic [WADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;
  } map_req_t;

  // Bits of map word w whose block number b satisfies lo <= b < hi.
  function automatic logic [WORD_W-1:0] range_mask(input logic [WADDR_W-1:0] w,
                                                    input logic [BLK_W:0] lo,
                                                    input logic [BLK_W:0] hi);
    logic [WADDR_W:0]  wx;
    logic [WORD_W-1:0] ge;
    logic [WORD_W-1:0] lt;
    wx = {1'b0, w};
    if (wx > lo[BLK_W:5]) begin
      ge = '1;
    end else if (wx == lo[BLK_W:5]) begin
      ge = {WORD_W{1'b1}} << lo[4:0];
    end else begin
      ge = '0;
    end
    if (wx < hi[BLK_W:5]) begin
      lt = '1;
    end else if (wx == hi[BLK_W:5]) begin
      lt = ~({WORD_W{1'b1}} << hi[4:0]);
    end else begin
      lt = '0;
    end
    return ge & lt;
  endfunction

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [4:0] lowest_one(input logic [WORD_W-1:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) idx = 5'(i);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/core/bba_if.sv =====
// Request and response channels of the block allocator.
interface bba_req_if import bba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [BLK_W-1:0]   block_number;
  logic [WADDR_W-1:0] word_index;
  logic [WORD_W-1:0]  word_value;

  modport source (output valid, action, block_number, word_index, word_value, input ready);
  modport sink (input valid, action, block_number, word_index, word_value, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BLK_W-1:0]  granted_block;
  logic              success;
  logic [WORD_W-1:0] map_word;
  logic              map_dirty;

  modport source (output valid, granted_block, success, map_word, map_dirty, input ready);
  modport sink (input valid, granted_block, success, map_word, map_dirty, output ready);
endinterface

// ===== rtl/core/bba_map_store.sv =====
// Usage map RAM with one read and one write port and per-word valid bits.
module bba_map_store import bba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  map_req_t          map_req,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0]    mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] word_valid;
  logic [WORD_W-1:0]    rd_q;
  logic                 rd_valid_q;

  // RAM array, read data registered.
  always_ff @(posedge clk) begin
    if (map_req.wr_en) begin
      mem[map_req.wr_addr] <= map_req.wr_data;
    end
    if (map_req.rd_en) begin
      rd_q       <= mem[map_req.rd_addr];
      rd_valid_q <= word_valid[map_req.rd_addr];
    end
  end

  // A word never written since reset reads as all zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (map_req.wr_en) begin
      word_valid[map_req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

// ===== rtl/core/bitmap_block_allocator_top.sv =====
// Top level of the next-fit bitmap block allocator.
//
//   channel  dir  handshake     word
//   req      in   valid/ready   action, block_number, word_index, word_value
//   rsp      out  valid/ready   granted_block, success, map_word, map_dirty
//   apb      in   psel/penable  12-bit registers at 0x0, 0x4, 0x8
//
// One request is worked at a time. Load, mark clean, unknown actions and a refused free
// go from idle straight to the done state; an accepted free and read pass through the
// read-modify-write state, and format writes one map word per cycle. Allocate scans the
// map; the single read port of the map RAM, fed one word per cycle, bounds its speed.
// Reset clears all valid bits of the map at once; there is no clearing pass.
// The response sits in an output register, so a new request is taken while it waits.
module bitmap_block_allocator_top import bba_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  bba_req_if.sink            req,
  bba_rsp_if.source          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RMW  = 3'd2;
  localparam logic [2:0] S_FMT  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]         state;
  logic [BLK_W-1:0]   cfg_first;
  logic [BLK_W-1:0]   cfg_rstart;
  logic [BLK_W-1:0]   cfg_rblocks;
  logic [BLK_W-1:0]   hint;
  logic               dirty;
  logic [2:0]         act;
  logic [BLK_W-1:0]   blk;
  logic [BLK_W-1:0]   first_q;
  logic [BLK_W-1:0]   start_q;
  logic [WADDR_W-1:0] issue_w;
  logic               issue_ph;
  logic               issue_on;
  logic [WADDR_W-1:0] ev_w;
  logic               ev_ph;
  logic               ev_on;
  logic               ev_last;
  logic [WADDR_W-1:0] fmt_w;
  logic [BLK_W-1:0]   res_granted;
  logic               res_success;
  logic [WORD_W-1:0]  res_word;
  logic               rsp_valid_q;
  logic [BLK_W-1:0]   rsp_granted;
  logic               rsp_success;
  logic [WORD_W-1:0]  rsp_word;
  logic               rsp_dirty;

  logic               accept;
  logic               cfg_wr;
  logic [BLK_W-1:0]   first_blk;
  logic [BLK_W-1:0]   start_c;
  logic               free_ok;
  map_req_t           map_req;
  logic [WORD_W-1:0]  rd_data;
  logic               p2_exists;
  logic [BLK_W-1:0]   start_m1;
  logic [BLK_W:0]     hi2;
  logic               issue_last;
  logic [WORD_W-1:0]  cand;
  logic [4:0]         hit_k;
  logic               found;
  logic [BLK_W-1:0]   hit_blk;
  logic [BLK_W:0]     region_end;
  logic [WORD_W-1:0]  fmt_word;

  bba_map_store u_map (
    .clk     (clk),
    .rst     (rst),
    .map_req (map_req),
    .rd_data (rd_data)
  );

  assign accept = req.valid && req.ready;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // Configuration readback.
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_FIRST:   prdata = 32'(cfg_first);
      REG_RSTART:  prdata = 32'(cfg_rstart);
      REG_RBLOCKS: prdata = 32'(cfg_rblocks);
      default:     prdata = '0;
    endcase
  end

  // A first block of zero acts as one; the search never starts below it.
  assign first_blk = (cfg_first == '0) ? BLK_W'(1) : cfg_first;
  assign start_c   = (hint < first_blk) ? first_blk : hint;
  assign free_ok   = (req.block_number >= first_blk) && ({1'b0, req.block_number} < LIMIT_BLK);

  // Scan bounds: first pass from start to the end, second from the first block up to start.
  assign p2_exists  = start_q > first_q;
  assign start_m1   = start_q - BLK_W'(1);
  assign hi2        = ({1'b0, start_q} < LIMIT_BLK) ? {1'b0, start_q} : LIMIT_BLK;
  assign issue_last = issue_ph ? (issue_w == start_m1[BLK_W-1:5])
                               : ((issue_w == LAST_WORD) && !p2_exists);

  // Free blocks of the word under evaluation, limited to the pass's range.
  assign cand    = ~rd_data & (ev_ph ? range_mask(ev_w, {1'b0, first_q}, hi2)
                                     : range_mask(ev_w, {1'b0, start_q}, LIMIT_BLK));
  assign hit_k   = lowest_one(cand);
  assign found   = (state == S_SCAN) && ev_on && (cand != '0);
  assign hit_blk = {ev_w, hit_k};

  // Format pattern: reserved blocks plus the saved-map region.
  assign region_end = {1'b0, cfg_rstart} + {1'b0, cfg_rblocks};
  assign fmt_word   = range_mask(fmt_w, '0, {1'b0, first_blk})
                    | range_mask(fmt_w, {1'b0, cfg_rstart}, region_end);

  // Map RAM requests.
  always_comb begin
    map_req = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.action)
            ACT_FREE: begin
              map_req.rd_en   = free_ok;
              map_req.rd_addr = req.block_number[BLK_W-1:5];
            end
            ACT_READ: begin
              map_req.rd_en   = 1'b1;
              map_req.rd_addr = req.word_index;
            end
            ACT_LOAD: begin
              map_req.wr_en   = 1'b1;
              map_req.wr_addr = req.word_index;
              map_req.wr_data = req.word_value;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        map_req.rd_en   = issue_on;
        map_req.rd_addr = issue_w;
        if (found) begin
          map_req.wr_en   = 1'b1;
          map_req.wr_addr = ev_w;
          map_req.wr_data = rd_data | (WORD_W'(1) << hit_k);
        end
      end
      S_RMW: begin
        if (act == ACT_FREE) begin
          map_req.wr_en   = 1'b1;
          map_req.wr_addr = blk[BLK_W-1:5];
          map_req.wr_data = rd_data & ~(WORD_W'(1) << blk[4:0]);
        end
      end
      S_FMT: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_addr = fmt_w;
        map_req.wr_data = fmt_word;
      end
      default: ;
    endcase
  end

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cfg_first   <= FIRST_RESET;
      cfg_rstart  <= RSTART_RESET;
      cfg_rblocks <= RBLOCKS_RESET;
      hint        <= HINT_RESET;
      dirty       <= 1'b0;
      issue_on    <= 1'b0;
      ev_on       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_FIRST:   cfg_first   <= pwdata[BLK_W-1:0];
          REG_RSTART:  cfg_rstart  <= pwdata[BLK_W-1:0];
          REG_RBLOCKS: cfg_rblocks <= pwdata[BLK_W-1:0];
          default: ;
        endcase
      end

      if (rsp_valid_q && rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            act         <= req.action;
            blk         <= req.block_number;
            res_granted <= '0;
            res_success <= 1'b0;
            res_word    <= '0;
            unique case (req.action) inside
              ACT_ALLOC: begin
                first_q  <= first_blk;
                start_q  <= start_c;
                issue_w  <= start_c[BLK_W-1:5];
                issue_ph <= 1'b0;
                issue_on <= 1'b1;
                ev_on    <= 1'b0;
                state    <= S_SCAN;
              end
              ACT_FREE: begin
                state <= free_ok ? S_RMW : S_DONE;
              end
              ACT_FORMAT: begin
                fmt_w <= '0;
                state <= S_FMT;
              end
              ACT_LOAD, ACT_CLEAN: begin
                dirty       <= 1'b0;
                res_success <= 1'b1;
                state       <= S_DONE;
              end
              ACT_READ: begin
                state <= S_RMW;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        S_SCAN: begin
          // Read one word per cycle; the previous word is evaluated meanwhile.
          ev_on   <= issue_on;
          ev_w    <= issue_w;
          ev_ph   <= issue_ph;
          ev_last <= issue_last;
          if (issue_on) begin
            if (!issue_ph && (issue_w == LAST_WORD)) begin
              if (p2_exists) begin
                issue_ph <= 1'b1;
                issue_w  <= first_q[BLK_W-1:5];
              end else begin
                issue_on <= 1'b0;
              end
            end else if (issue_ph && (issue_w == start_m1[BLK_W-1:5])) begin
              issue_on <= 1'b0;
            end else begin
              issue_w <= issue_w + WADDR_W'(1);
            end
          end
          if (found) begin
            hint        <= hit_blk + BLK_W'(1);
            dirty       <= 1'b1;
            res_granted <= hit_blk;
            res_success <= 1'b1;
            issue_on    <= 1'b0;
            state       <= S_DONE;
          end else if (ev_on && ev_last) begin
            issue_on <= 1'b0;
            state    <= S_DONE;
          end
        end

        S_RMW: begin
          if (act == ACT_FREE) begin
            dirty <= 1'b1;
            if (blk < hint) begin
              hint <= blk;
            end
          end else begin
            res_word <= rd_data;
          end
          res_success <= 1'b1;
          state       <= S_DONE;
        end

        S_FMT: begin
          fmt_w <= fmt_w + WADDR_W'(1);
          if (fmt_w == LAST_WORD) begin
            dirty       <= 1'b1;
            res_success <= 1'b1;
            state       <= S_DONE;
          end
        end

        S_DONE: begin
          if (!rsp_valid_q || rsp.ready) begin
            rsp_valid_q <= 1'b1;
            rsp_granted <= res_granted;
            rsp_success <= res_success;
            rsp_word    <= res_word;
            rsp_dirty   <= dirty;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid_q;
  assign rsp.granted_block = rsp_granted;
  assign rsp.success       = rsp_success;
  assign rsp.map_word      = rsp_word;
  assign rsp.map_dirty     = rsp_dirty;

endmodule

// ===== rtl/core/bba_checker.sv =====
// Port-level checker of the block allocator and its bind to the top level.
`include "bitmap_block_allocator_top_assert.svh"

module bba_checker import bba_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [BLK_W-1:0]  granted_block,
  input logic              success,
  input logic [WORD_W-1:0] map_word,
  input logic              map_dirty
);

  // A waiting response holds.
  `BBA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(granted_block) && $stable(map_word))

  // One request at a time: the block is busy right after taking one.
  `BBA_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)

  // A granted block means success and a changed map.
  `BBA_ASSERT_SAME(a_grant_dirty, clk, rst, rsp_valid && (granted_block != '0), success && map_dirty)

  // A nonzero map word comes only from a successful read.
  `BBA_ASSERT_SAME(a_word_success, clk, rst, rsp_valid && (map_word != '0), success && (granted_block == '0))

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .granted_block (rsp.granted_block),
  .success       (rsp.success),
  .map_word      (rsp.map_word),
  .map_dirty     (rsp.map_dirty)
);

// ===== tb/sv/tb_bitmap_block_allocator_top.sv =====
// Self-checking testbench of the next-fit bitmap block allocator.
`timescale 1ns / 100ps

import bba_pkg::*;

// Actions that the block leaves without effect.
localparam logic [2:0] ACT_SPARE_LO = 3'd6;
localparam logic [2:0] ACT_SPARE_HI = 3'd7;

typedef struct packed {
  logic [2:0]         action;
  logic [BLK_W-1:0]   block_number;
  logic [WADDR_W-1:0] word_index;
  logic [WORD_W-1:0]  word_value;
} alloc_req_t;

typedef struct packed {
  logic [BLK_W-1:0]  granted_block;
  logic              success;
  logic [WORD_W-1:0] map_word;
  logic              map_dirty;
} alloc_rsp_t;

// Mirror of the allocator state plus the queue of responses still owed by the block.
class alloc_scoreboard;
  bit [WORD_W-1:0] usage_map [MAP_WORDS];
  bit [BLK_W-1:0]  search_hint;
  bit              dirty;
  bit [BLK_W-1:0]  first_object;
  bit [BLK_W-1:0]  region_start;
  bit [BLK_W-1:0]  region_blocks;
  bit [BLK_W-1:0]  last_grant;
  alloc_rsp_t      pending_results [$];
  int              mismatches;

  function new();
    foreach (usage_map[w]) usage_map[w] = '0;
    search_hint   = HINT_RESET;
    dirty         = 1'b0;
    first_object  = FIRST_RESET;
    region_start  = RSTART_RESET;
    region_blocks = RBLOCKS_RESET;
    last_grant    = FIRST_RESET;
    mismatches    = 0;
  endfunction

  function void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR at %0t ns: %s", $time, msg);
  endfunction

  function void set_register(logic [1:0] idx, logic [BLK_W-1:0] val);
    case (idx)
      REG_FIRST:   first_object = val;
      REG_RSTART:  region_start = val;
      REG_RBLOCKS: region_blocks = val;
      default: ;
    endcase
  endfunction

  // A zero register value behaves as one, so block 0 is never handed out.
  function int first_usable();
    return (first_object == 0) ? 1 : int'(first_object);
  endfunction

  function bit is_used(int b);
    if (b >= MAP_BITS) return 1'b1;
    return usage_map[b >> 5][b & 31];
  endfunction

  function void put_bit(int b, bit v);
    if (b >= MAP_BITS) return;
    usage_map[b >> 5][b & 31] = v;
    dirty = 1'b1;
  endfunction

  // Next-fit search: hint to the top of the disk, then wrap to the object area.
  function bit [BLK_W-1:0] allocate_block();
    int first_blk;
    int start;
    int hit;
    first_blk = first_usable();
    start = (int'(search_hint) < first_blk) ? first_blk : int'(search_hint);
    hit = -1;
    for (int b = start; b < DISK_LIMIT && hit < 0; b++) begin
      if (!is_used(b)) hit = b;
    end
    for (int b = first_blk; b < start && b < DISK_LIMIT && hit < 0; b++) begin
      if (!is_used(b)) hit = b;
    end
    if (hit < 0) return '0;
    put_bit(hit, 1'b1);
    search_hint = BLK_W'(hit + 1);
    last_grant = BLK_W'(hit);
    return BLK_W'(hit);
  endfunction

  // Works out the response to an accepted request and updates the mirror.
  function void note_request(alloc_req_t r);
    alloc_rsp_t e;
    int region_end;
    e = '0;
    case (r.action)
      ACT_ALLOC: begin
        e.granted_block = allocate_block();
        e.success = (e.granted_block != '0);
      end
      ACT_FREE: begin
        if (int'(r.block_number) >= first_usable() && int'(r.block_number) < DISK_LIMIT) begin
          put_bit(int'(r.block_number), 1'b0);
          if (r.block_number < search_hint) search_hint = r.block_number;
          e.success = 1'b1;
        end
      end
      ACT_FORMAT: begin
        foreach (usage_map[w]) usage_map[w] = '0;
        for (int b = 0; b < first_usable(); b++) put_bit(b, 1'b1);
        region_end = int'(region_start) + int'(region_blocks);
        for (int b = int'(region_start); b < region_end && b < MAP_BITS; b++) put_bit(b, 1'b1);
        dirty = 1'b1;
        e.success = 1'b1;
      end
      ACT_LOAD: begin
        usage_map[r.word_index] = r.word_value;
        dirty = 1'b0;
        e.success = 1'b1;
      end
      ACT_READ: begin
        e.map_word = usage_map[r.word_index];
        e.success = 1'b1;
      end
      ACT_CLEAN: begin
        dirty = 1'b0;
        e.success = 1'b1;
      end
      default: ;
    endcase
    e.map_dirty = dirty;
    pending_results.push_back(e);
  endfunction

  function void check_response(alloc_rsp_t got);
    alloc_rsp_t e;
    if (pending_results.size() == 0) begin
      flag_error($sformatf("unexpected response: block %0d ok %b word %h dirty %b",
                           got.granted_block, got.success, got.map_word, got.map_dirty));
      return;
    end
    e = pending_results.pop_front();
    if (got.granted_block !== e.granted_block)
      flag_error($sformatf("granted_block expected %0d, got %0d",
                           e.granted_block, got.granted_block));
    if (got.success !== e.success)
      flag_error($sformatf("success expected %b, got %b", e.success, got.success));
    if (got.map_word !== e.map_word)
      flag_error($sformatf("map_word expected %h, got %h", e.map_word, got.map_word));
    if (got.map_dirty !== e.map_dirty)
      flag_error($sformatf("map_dirty expected %b, got %b", e.map_dirty, got.map_dirty));
  endfunction
endclass

module tb_bitmap_block_allocator_top;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  alloc_scoreboard sb;
  int              calm_items;

  bitmap_block_allocator_top dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // Watch both channels; a request is noted before any response of the same edge.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      sb.note_request('{req_ch.action, req_ch.block_number, req_ch.word_index,
                        req_ch.word_value});
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_response('{rsp_ch.granted_block, rsp_ch.success, rsp_ch.map_word,
                          rsp_ch.map_dirty});
    end
  end

  // Response back-pressure: short stalls, a few long ones, and calm stretches.
  initial begin
    int stall_left;
    int calm;
    int r;
    stall_left = 0;
    calm = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (calm > 0) begin
          calm--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 2) stall_left = $urandom_range(15, 50);
          else if (r < 22) stall_left = $urandom_range(1, 3);
          else if (r < 26) calm = $urandom_range(20, 200);
        end
      end
    end
  end

  // Idle cycles before the next request word.
  function automatic int pick_gap();
    int r;
    if (calm_items > 0) begin
      calm_items--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm_items = $urandom_range(10, 60);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Drives one request word and waits until it is taken.
  task automatic send_request(input logic [2:0] action, input logic [BLK_W-1:0] blk,
                              input logic [WADDR_W-1:0] widx,
                              input logic [WORD_W-1:0] wval);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.action       <= action;
    req_ch.block_number <= blk;
    req_ch.word_index   <= widx;
    req_ch.word_value   <= wval;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // One APB transfer: setup phase, access phase, then back to idle.
  task automatic apb_access(input bit wr, input logic [1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes a register with junk in the upper bits, then reads it back.
  task automatic write_register(input logic [1:0] idx, input logic [BLK_W-1:0] val);
    logic [31:0] wdata;
    logic [31:0] rdata;
    wdata = $urandom();
    wdata[BLK_W-1:0] = val;
    apb_access(1'b1, idx, wdata, rdata);
    sb.set_register(idx, val);
    apb_access(1'b0, idx, '0, rdata);
    if (rdata !== {{(32 - BLK_W){1'b0}}, val})
      sb.flag_error($sformatf("register %0d read expected %h, got %h", idx, val, rdata));
  endtask

  // Lets the block finish everything in flight.
  task automatic drain_block();
    req_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Fills the whole map except a hole or two, mostly near the top of the disk.
  task automatic fill_map();
    int hole;
    logic [WORD_W-1:0] wval;
    hole = $urandom_range(0, 1) ? MAP_WORDS - 1 : $urandom_range(0, MAP_WORDS - 1);
    for (int w = 0; w < MAP_WORDS; w++) begin
      wval = '1;
      if (w == hole) begin
        wval[$urandom_range(0, 31)] = 1'b0;
        wval[$urandom_range(0, 31)] = 1'b0;
      end
      send_request(ACT_LOAD, BLK_W'($urandom_range(0, 4095)), WADDR_W'(w), wval);
    end
  endtask

  // One random request, biased toward allocate and free of recently granted blocks.
  task automatic issue_random_item();
    int r;
    int first_blk;
    logic [2:0] action;
    logic [BLK_W-1:0] blk;
    logic [WORD_W-1:0] wval;
    first_blk = sb.first_usable();
    blk = BLK_W'($urandom_range(0, 4095));
    wval = $urandom();
    r = $urandom_range(0, 99);
    if (r < 40) action = ACT_ALLOC;
    else if (r < 62) action = ACT_FREE;
    else if (r < 65) action = ACT_FORMAT;
    else if (r < 75) action = ACT_LOAD;
    else if (r < 87) action = ACT_READ;
    else if (r < 93) action = ACT_CLEAN;
    else action = $urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
    if (action == ACT_FREE) begin
      r = $urandom_range(0, 99);
      if (r < 45) blk = sb.last_grant - BLK_W'($urandom_range(0, 8));
      else if (r < 75) blk = BLK_W'($urandom_range(0, first_blk - 1));
      else if (r < 85) blk = BLK_W'(first_blk + $urandom_range(0, 63));
    end
    if (action == ACT_LOAD) begin
      r = $urandom_range(0, 99);
      if (r < 30) wval = '1;
      else if (r < 40) wval = '0;
    end
    send_request(action, blk, WADDR_W'($urandom_range(0, MAP_WORDS - 1)), wval);
  endtask

  // Stimulus: reset, directed checks, then register phases with random traffic.
  initial begin
    logic [BLK_W-1:0] cfg_first;
    logic [BLK_W-1:0] cfg_rstart;
    logic [BLK_W-1:0] cfg_rblocks;
    sb = new();
    calm_items = 0;
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.action       <= ACT_ALLOC;
    req_ch.block_number <= '0;
    req_ch.word_index   <= '0;
    req_ch.word_value   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: basic allocate, double free, refused frees, format and word access.
    send_request(ACT_READ, 12'd0, 7'd0, '0);
    send_request(ACT_ALLOC, 12'd0, 7'd0, '0);
    send_request(ACT_ALLOC, 12'd4095, 7'd127, '1);
    send_request(ACT_FREE, 12'd16, 7'd0, '0);
    send_request(ACT_FREE, 12'd16, 7'd0, '0);
    send_request(ACT_FREE, 12'd15, 7'd0, '0);
    send_request(ACT_FREE, 12'd0, 7'd0, '0);
    send_request(ACT_FREE, 12'd4095, 7'd0, '0);
    send_request(ACT_FORMAT, 12'd0, 7'd0, '0);
    send_request(ACT_READ, 12'd0, 7'd0, '0);
    send_request(ACT_CLEAN, 12'd0, 7'd0, '0);
    send_request(ACT_LOAD, 12'd0, 7'd127, 32'h7FFF_FFFF);
    send_request(ACT_READ, 12'd0, 7'd127, '0);
    send_request(ACT_SPARE_LO, 12'd4095, 7'd127, '1);
    send_request(ACT_SPARE_HI, 12'd0, 7'd0, '0);

    for (int phase = 0; phase < 7; phase++) begin
      if (phase > 0) begin
        drain_block();
        case (phase)
          1: begin
            cfg_first = 12'd0;
            cfg_rstart = 12'd0;
            cfg_rblocks = 12'd0;
          end
          2: begin
            cfg_first = 12'd4095;
            cfg_rstart = 12'd4095;
            cfg_rblocks = 12'd4095;
          end
          3: begin
            cfg_first = 12'd1;
            cfg_rstart = 12'd4000;
            cfg_rblocks = 12'd200;
          end
          6: begin
            cfg_first = FIRST_RESET;
            cfg_rstart = RSTART_RESET;
            cfg_rblocks = RBLOCKS_RESET;
          end
          default: begin
            cfg_first = BLK_W'($urandom_range(1, 300));
            cfg_rstart = BLK_W'($urandom_range(0, 4095));
            cfg_rblocks = BLK_W'($urandom_range(0, 64));
          end
        endcase
        write_register(REG_FIRST, cfg_first);
        write_register(REG_RSTART, cfg_rstart);
        write_register(REG_RBLOCKS, cfg_rblocks);
      end

      // Zero first object block: block 0 stays reserved and is never granted.
      if (phase == 1) begin
        send_request(ACT_FORMAT, 12'd0, 7'd0, '0);
        send_request(ACT_READ, 12'd0, 7'd0, '0);
        send_request(ACT_ALLOC, 12'd0, 7'd0, '0);
        send_request(ACT_FREE, 12'd0, 7'd0, '0);
      end

      // Only the top block is allocatable: full map, and the hint wrapping past the end.
      if (phase == 2) begin
        send_request(ACT_FORMAT, 12'd0, 7'd0, '0);
        send_request(ACT_ALLOC, 12'd0, 7'd0, '0);
        send_request(ACT_FREE, 12'd4095, 7'd0, '0);
        send_request(ACT_ALLOC, 12'd0, 7'd0, '0);
        send_request(ACT_ALLOC, 12'd0, 7'd0, '0);
        send_request(ACT_FREE, 12'd4094, 7'd0, '0);
      end

      // Map region running past the last block.
      if (phase == 3) begin
        send_request(ACT_FORMAT, 12'd0, 7'd0, '0);
        send_request(ACT_READ, 12'd0, 7'd127, '0);
      end

      for (int n = 0; n < 215; n++) begin
        if (phase % 2 == 1 && n == 40) begin
          fill_map();
          n += MAP_WORDS;
        end
        issue_random_item();
      end
    end

    // Wait for the last responses, then allow the block to go quiet.
    drain_block();
    repeat (140) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.flag_error($sformatf("%0d responses never arrived", sb.pending_results.size()));
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #25ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
